// ===== src/bitmap_frame_allocator_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the bitmap frame allocator
// Same-cycle and next-cycle implication checks on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BITMAP_FRAME_ALLOCATOR_ASSERT_SVH
`define BITMAP_FRAME_ALLOCATOR_ASSERT_SVH

// check cons in the cycle of ante
`define BFA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// check cons in the cycle after ante
`define BFA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/bfa_pkg.sv =====
// ----------------------------------------------------------------------------
// bfa_pkg
// Constants and types of the bitmap frame allocator.
// ----------------------------------------------------------------------------
package bfa_pkg;

  localparam int MAX_FRAMES = 4096;
  localparam int WORD_BITS  = 32;
  localparam int WORD_COUNT = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int WORD_AW    = $clog2(WORD_COUNT);
  localparam int BIT_AW     = $clog2(WORD_BITS);
  localparam int FRAME_W    = 12;
  localparam int COUNT_W    = 13;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 24;

  localparam logic [COUNT_W-1:0] FRAME_LIMIT = COUNT_W'(4096);
  localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(4096);

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  typedef enum logic [1:0] {
    STAT_DONE = 2'd0,
    STAT_NOP  = 2'd1,
    STAT_FULL = 2'd2
  } bfa_status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FREE,
    ST_DONE
  } bfa_state_t;

  typedef struct packed {
    bfa_status_t        status;
    logic [FRAME_W-1:0] frame_out;
    logic               user_mode;
    logic               writable;
    logic               present;
  } bfa_result_t;

endpackage

// ===== src/bitmap_frame_allocator.sv =====
// ----------------------------------------------------------------------------
// bitmap_frame_allocator
// First-fit page-frame allocator over a bitmap of 32-bit words in one
// synchronous memory, one bit per frame.
// ----------------------------------------------------------------------------
// One request at a time. An allocate for a page entry without a frame reads
// the bitmap one word per cycle through the single read port, starting at
// word 0, and takes the lowest clear bit below frame_count. A free reads
// the word, writes it back and then loads the result; a request with
// nothing to do goes straight to loading the result. A new request is taken
// while the previous result still waits in the output register. After reset
// every frame is free at once: per-word valid bits stand in for a clearing
// pass.
// ----------------------------------------------------------------------------
`include "bitmap_frame_allocator_assert.svh"

module bitmap_frame_allocator (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [bfa_pkg::COUNT_W-1:0]      cfg_wr_data,  // frame_count
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [bfa_pkg::IN_DATA_W-1:0]    in_tdata,     // page_frame, kernel_only, write_ok
  input  logic                             in_tuser,     // action
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [bfa_pkg::OUT_DATA_W-1:0]   out_tdata     // present, writable, user_mode,
                                                         // frame_out, status
);

  localparam int AW = bfa_pkg::WORD_AW;
  localparam int BW = bfa_pkg::BIT_AW;
  localparam int DW = bfa_pkg::WORD_BITS;
  localparam int FW = bfa_pkg::FRAME_W;
  localparam int CW = bfa_pkg::COUNT_W;
  localparam int RW = $bits(bfa_pkg::bfa_result_t);

  bfa_pkg::bfa_state_t  state_r, state_nxt;
  bfa_pkg::bfa_result_t res_r, res_nxt;

  logic [CW-1:0]                  frame_count_r;
  logic [bfa_pkg::WORD_COUNT-1:0] valid_r;
  logic [DW-1:0]                  mem [bfa_pkg::WORD_COUNT];
  logic [DW-1:0]                  mem_q_r;
  logic                           vld_q_r;
  logic [AW-1:0]                  rd_addr_q_r;
  logic [AW-1:0]                  scan_addr_r, scan_addr_nxt;
  logic [BW-1:0]                  bit_r, bit_nxt;
  logic                           kern_r, kern_nxt;
  logic                           wr_r, wr_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [RW-1:0]                  out_data_r;
  logic                           out_load;

  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [DW-1:0] wr_data;
  logic [DW-1:0] rd_word;
  logic [CW-1:0] lim;
  logic [CW-AW-BW+AW-1:0] lim_w;
  logic [DW-1:0] in_range;
  logic [DW-1:0] avail;
  logic          found;
  logic [BW-1:0] zero_idx;
  logic          last_word;
  logic [FW-1:0] in_frame;
  logic [CW-1:0] next_start;

  assign in_frame  = in_tdata[FW-1:0];
  assign rd_word   = vld_q_r ? mem_q_r : '0;
  assign lim       = (frame_count_r > bfa_pkg::FRAME_LIMIT) ? bfa_pkg::FRAME_LIMIT
                                                            : frame_count_r;
  assign lim_w     = lim[CW-1:BW];

  always_comb begin
    if ({1'b0, rd_addr_q_r} < lim_w) begin
      in_range = '1;
    end else if ({1'b0, rd_addr_q_r} == lim_w) begin
      in_range = ~({DW{1'b1}} << lim[BW-1:0]);
    end else begin
      in_range = '0;
    end
  end

  assign avail = ~rd_word & in_range;
  assign found = |avail;

  always_comb begin
    zero_idx = '0;
    for (int b = DW - 1; b >= 0; b--) begin
      if (avail[b]) zero_idx = BW'(b);
    end
  end

  assign next_start = {(CW-BW)'({1'b0, rd_addr_q_r} + (AW+1)'(1)), {BW{1'b0}}};
  assign last_word  = (rd_addr_q_r == AW'(bfa_pkg::WORD_COUNT - 1)) || (next_start >= lim);

  always_comb begin
    state_nxt     = state_r;
    res_nxt       = res_r;
    scan_addr_nxt = scan_addr_r;
    bit_nxt       = bit_r;
    kern_nxt      = kern_r;
    wr_nxt        = wr_r;
    in_tready     = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = scan_addr_r;
    wr_en         = 1'b0;
    wr_addr       = rd_addr_q_r;
    wr_data       = rd_word;
    out_load      = 1'b0;
    case (state_r)
      bfa_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          kern_nxt          = in_tdata[FW];
          wr_nxt            = in_tdata[FW+1];
          res_nxt           = '0;
          res_nxt.status    = bfa_pkg::STAT_NOP;
          if (in_tuser == bfa_pkg::ACT_ALLOC) begin
            if (in_frame != '0) begin
              res_nxt.frame_out = in_frame;
              state_nxt         = bfa_pkg::ST_DONE;
            end else begin
              rd_en         = 1'b1;
              rd_addr       = '0;
              scan_addr_nxt = AW'(1);
              state_nxt     = bfa_pkg::ST_SCAN;
            end
          end else begin
            if (in_frame != '0) begin
              rd_en          = 1'b1;
              rd_addr        = in_frame[FW-1:BW];
              bit_nxt        = in_frame[BW-1:0];
              res_nxt.status = bfa_pkg::STAT_DONE;
              state_nxt      = bfa_pkg::ST_FREE;
            end else begin
              state_nxt = bfa_pkg::ST_DONE;
            end
          end
        end
      end
      bfa_pkg::ST_SCAN: begin
        if (found) begin
          wr_en             = 1'b1;
          wr_data           = rd_word | (DW'(1) << zero_idx);
          res_nxt.present   = 1'b1;
          res_nxt.writable  = wr_r;
          res_nxt.user_mode = ~kern_r;
          res_nxt.frame_out = {rd_addr_q_r, zero_idx};
          res_nxt.status    = bfa_pkg::STAT_DONE;
          state_nxt         = bfa_pkg::ST_DONE;
        end else if (last_word) begin
          res_nxt.frame_out = '0;
          res_nxt.status    = bfa_pkg::STAT_FULL;
          state_nxt         = bfa_pkg::ST_DONE;
        end else begin
          rd_en         = 1'b1;
          rd_addr       = scan_addr_r;
          scan_addr_nxt = scan_addr_r + AW'(1);
        end
      end
      bfa_pkg::ST_FREE: begin
        wr_en     = 1'b1;
        wr_data   = rd_word & ~(DW'(1) << bit_r);
        state_nxt = bfa_pkg::ST_DONE;
      end
      bfa_pkg::ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = bfa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = bfa_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r & ~out_tready;
    if (out_load) out_valid_nxt = 1'b1;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= bfa_pkg::ST_IDLE;
      out_valid_r   <= 1'b0;
      frame_count_r <= bfa_pkg::COUNT_RESET;
      valid_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) frame_count_r <= cfg_wr_data;
      if (wr_en) valid_r[wr_addr] <= 1'b1;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    res_r       <= res_nxt;
    scan_addr_r <= scan_addr_nxt;
    bit_r       <= bit_nxt;
    kern_r      <= kern_nxt;
    wr_r        <= wr_nxt;
    if (out_load) out_data_r <= res_r;
  end

  // bitmap memory, one read and one write port
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) begin
      mem_q_r     <= mem[rd_addr];
      vld_q_r     <= valid_r[rd_addr];
      rd_addr_q_r <= rd_addr;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(bfa_pkg::OUT_DATA_W - RW)'(0), out_data_r};

  `BFA_ASSERT_SAME(a_wr_state, wr_en, (state_r == bfa_pkg::ST_SCAN) || (state_r == bfa_pkg::ST_FREE), "bitmap write outside scan or free")
  `BFA_ASSERT_NEXT(a_wr_then_done, wr_en, state_r == bfa_pkg::ST_DONE, "bitmap write not followed by result")
  `BFA_ASSERT_SAME(a_alloc_one_bit, wr_en && (state_r == bfa_pkg::ST_SCAN), $countones(wr_data) == $countones(rd_word) + 1, "allocate must set exactly one new bit")
  `BFA_ASSERT_SAME(a_free_clears, wr_en && (state_r == bfa_pkg::ST_FREE), (wr_data & ~rd_word) == '0, "free must only clear bits")
  `BFA_ASSERT_NEXT(a_accept_busy, in_tvalid && in_tready, state_r != bfa_pkg::ST_IDLE, "accepted beat left block idle")

endmodule

// ===== tb/bfa_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfa_checker
// Watches the configuration port and both stream channels of the frame
// allocator. Keeps its own frame bitmap and frame count, works out the page
// entry that each request beat must produce, and compares every result beat
// field by field with the oldest entry waiting.
// ----------------------------------------------------------------------------
module bfa_checker
  import bfa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [COUNT_W-1:0]    cfg_wr_data,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // page_frame, kernel_only, write_ok
  input  logic                  in_tuser,   // action
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,  // present, writable, user_mode,
                                            // frame_out, status
  output int                    outstanding,
  output int                    mismatches
);

  bit                 frame_used [MAX_FRAMES];
  logic [COUNT_W-1:0] frame_count_q = COUNT_RESET;
  bfa_result_t        page_entry_q [$];

  function automatic bfa_result_t apply_request(input logic               action,
                                                input logic [FRAME_W-1:0] frame,
                                                input logic               kern,
                                                input logic               wr);
    bfa_result_t entry;
    int          bound;
    bit          found;
    entry        = '0;
    entry.status = STAT_NOP;
    found        = 1'b0;
    if (action == ACT_ALLOC) begin
      if (frame != '0) begin
        entry.frame_out = frame;
      end else begin
        bound = (frame_count_q > FRAME_LIMIT) ? int'(FRAME_LIMIT) : int'(frame_count_q);
        if (bound > MAX_FRAMES) bound = MAX_FRAMES;
        entry.status = STAT_FULL;
        for (int f = 0; f < bound; f++) begin
          if (!found && !frame_used[f]) begin
            found           = 1'b1;
            frame_used[f]   = 1'b1;
            entry.present   = 1'b1;
            entry.writable  = wr;
            entry.user_mode = ~kern;
            entry.frame_out = FRAME_W'(f);
            entry.status    = STAT_DONE;
          end
        end
      end
    end else if (frame != '0) begin
      if (int'(frame) < MAX_FRAMES) frame_used[frame] = 1'b0;
      entry.status = STAT_DONE;
    end
    return entry;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : monitor
    bfa_result_t want;
    bfa_result_t got;
    if (!rst_n) begin
      foreach (frame_used[i]) frame_used[i] = 1'b0;
      frame_count_q = COUNT_RESET;
      page_entry_q.delete();
    end else begin
      if (cfg_wr_en) frame_count_q = cfg_wr_data;
      if (in_tvalid && in_tready)
        page_entry_q.push_back(apply_request(in_tuser, in_tdata[FRAME_W-1:0],
                                             in_tdata[FRAME_W], in_tdata[FRAME_W+1]));
      if (out_tvalid && out_tready) begin
        got = bfa_result_t'(out_tdata[$bits(bfa_result_t)-1:0]);
        if (page_entry_q.size() == 0) begin
          $error("result beat with no request waiting");
          mismatches++;
        end else begin
          want = page_entry_q.pop_front();
          check_field("present", 32'(want.present), 32'(got.present));
          check_field("writable", 32'(want.writable), 32'(got.writable));
          check_field("user_mode", 32'(want.user_mode), 32'(got.user_mode));
          check_field("frame_out", 32'(want.frame_out), 32'(got.frame_out));
          check_field("status", 32'(want.status), 32'(got.status));
        end
      end
    end
    outstanding <= page_entry_q.size();
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the frame allocator with a directed set of page-entry requests and
// then random phases at several frame counts, including zero and values past
// the bitmap size. Both channels idle at random; the checker beside the
// block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module testbench;
  import bfa_pkg::*;

  localparam int LONG_HOLD   = 400;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int PHASES      = 10;

  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  cfg_wr_en   = 1'b0;
  logic [COUNT_W-1:0]    cfg_wr_data = '0;
  logic                  in_tvalid   = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata    = '0;  // page_frame, kernel_only, write_ok
  logic                  in_tuser    = 1'b0; // action
  logic                  out_tvalid;
  logic                  out_tready  = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;         // present, writable, user_mode,
                                            // frame_out, status

  int outstanding;
  int mismatches;
  int cycles      = 0;
  int hold_reqs   = 0;
  int holds_taken = 0;
  int rx_left     = 0;
  bit rx_gaps     = 1'b0;
  bit tx_gaps     = 1'b0;
  int cur_count   = 4096;
  int alloc_count = 0;

  int phase_count [PHASES] = '{4096, 0, 1, 37, 8191, 300, 4097, 64, 2000, 4096};
  int phase_items [PHASES] = '{600, 40, 40, 120, 200, 150, 150, 120, 100, 100};
  int phase_alloc [PHASES] = '{85, 50, 50, 55, 80, 55, 60, 55, 70, 50};

  bitmap_frame_allocator u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

  bfa_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .outstanding (outstanding),
    .mismatches  (mismatches)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 15);
    return $urandom_range(30, 80);
  endfunction

  // hold result beats off: random gaps, or one long stretch on request
  always @(posedge clk) begin
    if (hold_reqs != holds_taken) begin
      holds_taken <= hold_reqs;
      rx_left     <= LONG_HOLD;
      out_tready  <= 1'b0;
    end else if (rx_left != 0) begin
      rx_left    <= rx_left - 1;
      out_tready <= (rx_left == 1);
    end else if (rx_gaps && $urandom_range(0, 99) < 25) begin
      rx_left    <= gap_len();
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic send_item(input logic act, input logic [FRAME_W-1:0] frame,
                           input logic kern, input logic wr);
    int gap;
    gap = (tx_gaps && $urandom_range(0, 99) < 30) ? gap_len() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {2'b00, wr, kern, frame};
    if (act == ACT_ALLOC && frame == '0) alloc_count++;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic set_frame_count(input int value);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= COUNT_W'(value);
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    cur_count = value;
  endtask

  task automatic random_item(input int alloc_pct);
    int r;
    int hi;
    hi = (cur_count > 4096) ? 4096 : cur_count;
    if (alloc_count < hi) hi = alloc_count;
    hi = (hi + 1 > 4095) ? 4095 : hi + 1;
    r = $urandom_range(0, 99);
    if (r < alloc_pct) begin
      send_item(ACT_ALLOC, '0, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end else begin
      r = $urandom_range(0, 9);
      if (r < 2)
        send_item(ACT_ALLOC, FRAME_W'($urandom_range(1, 4095)),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      else if (r < 7)
        send_item(ACT_FREE, FRAME_W'($urandom_range(1, hi)),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      else if (r < 9)
        send_item(ACT_FREE, FRAME_W'($urandom_range(1, 4095)),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      else
        send_item(ACT_FREE, '0, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(ACT_ALLOC, '0, 1'b0, 1'b1);
    send_item(ACT_ALLOC, '0, 1'b1, 1'b0);
    send_item(ACT_ALLOC, '0, 1'b1, 1'b1);
    send_item(ACT_ALLOC, 12'hFFF, 1'b0, 1'b0);
    send_item(ACT_ALLOC, 12'd1, 1'b1, 1'b1);
    send_item(ACT_FREE, '0, 1'b0, 1'b0);
    send_item(ACT_FREE, 12'd1, 1'b1, 1'b1);
    send_item(ACT_FREE, 12'hFFF, 1'b0, 1'b1);
    send_item(ACT_ALLOC, '0, 1'b0, 1'b0);
    send_item(ACT_FREE, 12'd2, 1'b0, 1'b0);
    send_item(ACT_FREE, 12'd2, 1'b1, 1'b0);
    set_frame_count(0);
    send_item(ACT_ALLOC, '0, 1'b0, 1'b1);
    send_item(ACT_FREE, 12'd3, 1'b0, 1'b0);
    set_frame_count(1);
    send_item(ACT_ALLOC, '0, 1'b1, 1'b1);
    set_frame_count(3);
    send_item(ACT_ALLOC, '0, 1'b0, 1'b0);
    send_item(ACT_ALLOC, '0, 1'b0, 1'b1);
    set_frame_count(8191);
    send_item(ACT_ALLOC, '0, 1'b1, 1'b0);
    set_frame_count(4097);
    send_item(ACT_ALLOC, '0, 1'b0, 1'b1);

    for (int p = 0; p < PHASES; p++) begin
      set_frame_count(phase_count[p]);
      tx_gaps = (p % 4 != 1);
      rx_gaps <= (p % 4 != 2);
      for (int i = 0; i < phase_items[p]; i++) begin
        if (p == 0 && i == 100) hold_reqs <= hold_reqs + 1;
        if (i == phase_items[p] / 2) drain();
        random_item(phase_alloc[p]);
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
